// ----- design/sfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Types, constants and fixed-point helpers of the state feedback controller
// step: Q8.14 values, Q16.16 intermediates, round half up with saturation.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned DecW    = 22;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NStage  = 6;

  typedef logic signed [DecW-1:0]  dec_t;
  typedef logic signed [ProdW-1:0] prod_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_DRIVE = 3'd0,
    REG_COEF_STATE = 3'd1,
    REG_LOOP_GAIN  = 3'd2,
    REG_INPUT_SCALE = 3'd3,
    REG_DRIVE_MAX  = 3'd4,
    REG_DRIVE_MIN  = 3'd5
  } cfg_reg_e;

  localparam dec_t RstCoefDrive  = -22'sd2861;
  localparam dec_t RstCoefState  = 22'sd7188;
  localparam dec_t RstLoopGain   = 22'sd52668;
  localparam dec_t RstInputScale = 22'sd1;
  localparam dec_t RstDriveMax   = 22'sd2080768;
  localparam dec_t RstDriveMin   = 22'sd0;

  typedef struct packed {
    dec_t coef_drive;
    dec_t coef_state;
    dec_t loop_gain;
    dec_t input_scale;
    dec_t drive_max;
    dec_t drive_min;
  } sfc_cfg_t;

  // round half up by a right shift of n, then saturate to Q16.16
  function automatic prod_t rnd_q16(input logic signed [55:0] p, input logic [3:0] n);
    logic signed [55:0] sum;
    logic signed [55:0] sh;
    begin
      sum = p + (56'sd1 <<< (n - 4'd1));
      sh  = sum >>> n;
      if (sh > 56'sh7FFFFFFF) begin
        rnd_q16 = 32'sh7FFFFFFF;
      end else if (sh < -56'sh80000000) begin
        rnd_q16 = -32'sh80000000;
      end else begin
        rnd_q16 = sh[ProdW-1:0];
      end
    end
  endfunction

  // Q16.16 to Q8.14 with round half up and saturation
  function automatic dec_t to_q8(input prod_t v);
    logic signed [32:0] sum;
    logic signed [32:0] sh;
    begin
      sum = 33'(v) + 33'sd2;
      sh  = sum >>> 2;
      if (sh > 33'sd2097151) begin
        to_q8 = 22'sh1FFFFF;
      end else if (sh < -33'sd2097152) begin
        to_q8 = -22'sh200000;
      end else begin
        to_q8 = sh[DecW-1:0];
      end
    end
  endfunction

  // saturating Q8.14 add
  function automatic dec_t add_sat_q8(input dec_t a, input dec_t b);
    logic signed [22:0] sum;
    begin
      sum = 23'(a) + 23'(b);
      if (sum > 23'sd2097151) begin
        add_sat_q8 = 22'sh1FFFFF;
      end else if (sum < -23'sd2097152) begin
        add_sat_q8 = -22'sh200000;
      end else begin
        add_sat_q8 = sum[DecW-1:0];
      end
    end
  endfunction

  // count to Q16.16, saturating at the largest positive value
  function automatic prod_t count_q16(input logic [CountW-1:0] c);
    begin
      if (c[CountW-1]) begin
        count_q16 = 32'sh7FFFFFFF;
      end else begin
        count_q16 = prod_t'({c, 16'h0000});
      end
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/sfc_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_cfg_regs
// Configuration register file: coefficients, loop gain, input scale and
// drive limits, written one register per transfer.
// ----------------------------------------------------------------------------
module sfc_cfg_regs
  import sfc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [DecW-1:0]      cfg_data_i,
  output sfc_cfg_t                  cfg_o
);

  sfc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COEF_DRIVE:  cfg_d.coef_drive  = cfg_data_i;
        REG_COEF_STATE:  cfg_d.coef_state  = cfg_data_i;
        REG_LOOP_GAIN:   cfg_d.loop_gain   = cfg_data_i;
        REG_INPUT_SCALE: cfg_d.input_scale = cfg_data_i;
        REG_DRIVE_MAX:   cfg_d.drive_max   = cfg_data_i;
        REG_DRIVE_MIN:   cfg_d.drive_min   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_drive  <= RstCoefDrive;
      cfg_q.coef_state  <= RstCoefState;
      cfg_q.loop_gain   <= RstLoopGain;
      cfg_q.input_scale <= RstInputScale;
      cfg_q.drive_max   <= RstDriveMax;
      cfg_q.drive_min   <= RstDriveMin;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- design/state_feedback_controller_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// state_feedback_controller_step_core
// One step of a fixed-point state feedback controller with a clamped drive.
// ----------------------------------------------------------------------------
// Six-stage pipeline: an item enters every cycle while the input is not
// stalled and passes through the stages in order. Stage one forms the four
// input products (counts times input scale, previous drive and state times
// their weights), stage two rounds them to Q8.14, stage three sums the new
// state and the error, stage four multiplies by the loop gain, stage five
// rounds, and stage six clamps into the output register. Each stage holds
// while the one after it is full and stalled, so bubbles are squeezed out.
// Configuration writes are taken every cycle and should only be made idle.
// ----------------------------------------------------------------------------
module state_feedback_controller_step_core
  import sfc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [DecW-1:0]      cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [CountW-1:0]    reference_count_i,
  input  wire logic [CountW-1:0]    measured_count_i,
  input  wire logic [DecW-1:0]      prev_state_i,
  input  wire logic [DecW-1:0]      prev_drive_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DecW-1:0]           new_state_o,
  output logic [DecW-1:0]           drive_o
);

  sfc_cfg_t cfg;

  sfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic [NStage-1:0] valid_q, valid_d;
  logic [NStage-1:0] en;

  always_comb begin
    en[NStage-1] = !valid_q[NStage-1] || !out_stall_i;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d = valid_q;
    for (int k = 0; k < NStage; k++) begin
      if (en[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o = !en[0];

  // stage 1: products
  logic signed [53:0] prod_r_q, prod_r_d, prod_m_q, prod_m_d;
  logic signed [43:0] prod_a_q, prod_a_d, prod_b_q, prod_b_d;

  always_comb begin
    prod_r_d = 54'(cfg.input_scale) * 54'(count_q16(reference_count_i));
    prod_m_d = 54'(cfg.input_scale) * 54'(count_q16(measured_count_i));
    prod_a_d = 44'(cfg.coef_drive) * 44'(dec_t'(prev_drive_i));
    prod_b_d = 44'(cfg.coef_state) * 44'(dec_t'(prev_state_i));
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_r_q <= prod_r_d;
      prod_m_q <= prod_m_d;
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
  end

  // stage 2: round to Q16.16 then Q8.14
  dec_t vr_q, vr_d, vm_q, vm_d, ta_q, ta_d, tb_q, tb_d;

  always_comb begin
    vr_d = to_q8(rnd_q16(56'(prod_r_q), 4'd14));
    vm_d = to_q8(rnd_q16(56'(prod_m_q), 4'd14));
    ta_d = to_q8(rnd_q16(56'(prod_a_q), 4'd12));
    tb_d = to_q8(rnd_q16(56'(prod_b_q), 4'd12));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      vr_q <= vr_d;
      vm_q <= vm_d;
      ta_q <= ta_d;
      tb_q <= tb_d;
    end
  end

  // stage 3: new state and error
  dec_t               x0_s3_q, x0_s3_d;
  logic signed [23:0] err_q, err_d;

  always_comb begin
    x0_s3_d = add_sat_q8(ta_q, tb_q);
    err_d   = 24'(vr_q) - 24'(vm_q) - 24'(x0_s3_d);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x0_s3_q <= x0_s3_d;
      err_q   <= err_d;
    end
  end

  // stage 4: loop gain product
  dec_t               x0_s4_q;
  logic signed [45:0] prod_u_q, prod_u_d;

  assign prod_u_d = 46'(cfg.loop_gain) * 46'(err_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      x0_s4_q  <= x0_s3_q;
      prod_u_q <= prod_u_d;
    end
  end

  // stage 5: round the drive
  dec_t x0_s5_q, u_q, u_d;

  assign u_d = to_q8(rnd_q16(56'(prod_u_q), 4'd12));

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      x0_s5_q <= x0_s4_q;
      u_q     <= u_d;
    end
  end

  // stage 6: clamp, max limit first
  dec_t x0_out_q, drive_q, drive_d;

  always_comb begin
    if (u_q > cfg.drive_max) begin
      drive_d = cfg.drive_max;
    end else if (u_q < cfg.drive_min) begin
      drive_d = cfg.drive_min;
    end else begin
      drive_d = u_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      x0_out_q <= x0_s5_q;
      drive_q  <= drive_d;
    end
  end

  assign out_valid_o = valid_q[NStage-1];
  assign new_state_o = x0_out_q;
  assign drive_o     = drive_q;

endmodule
`default_nettype wire

// ----- design/sfc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks of the controller step: stall origin, empty after reset
// and hold of a stalled step and of a stalled result.
// ----------------------------------------------------------------------------
module sfc_checker
  import sfc_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [CountW-1:0]  reference_count_i,
  input wire logic [CountW-1:0]  measured_count_i,
  input wire logic [DecW-1:0]    prev_state_i,
  input wire logic [DecW-1:0]    prev_drive_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [DecW-1:0]    new_state_o,
  input wire logic [DecW-1:0]    drive_o
);

  // input side only stalls when a result is held at the output
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // a stalled step holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(reference_count_i) && $stable(measured_count_i) &&
       $stable(prev_state_i) && $stable(prev_drive_i)))
    else $error("stalled step changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(new_state_o) && $stable(drive_o)))
    else $error("stalled result changed");

endmodule

bind state_feedback_controller_step_core sfc_checker u_sfc_checker (.*);
`default_nettype wire
